// ----- hw/rtl/henon_escape_time_macros.svh -----
// Assertion macros shared by the Henon escape-time block.
`ifndef HENON_ESCAPE_TIME_MACROS_SVH
`define HENON_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, checked at every rising edge of clk outside reset.
`define HET_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge of clk outside reset.
`define HET_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/het_pkg.sv -----
// Shared types, constants and helper functions of the Henon escape-time block.
`timescale 1ns / 1ps

package het_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int RAD_W         = 31;
  localparam int CNT_W         = 12;
  localparam int CODE_W        = 9;
  localparam int CFG_IDX_W     = 4;
  localparam int SUM_W         = DATA_W + 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_C_OFFSET      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_GAIN        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_RADIUS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER      = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] C_OFFSET_RST      = 32'hFFFD_0000;
  localparam logic [DATA_W-1:0] A_GAIN_RST        = 32'h0000_4CCD;
  localparam logic [RAD_W-1:0]  ESCAPE_RADIUS_RST = 31'h0064_0000;
  localparam logic [CNT_W-1:0]  MAX_ITER_RST      = 12'd10;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  // Last value of the modulo-15 color counters.
  localparam logic [3:0] MOD_LAST = 4'd14;
  localparam logic [CODE_W-1:0] CODE_BOUNDED = 9'h1FF;

  // Multiplier operand selection.
  localparam logic [1:0] MUL_YY = 2'd0;
  localparam logic [1:0] MUL_AX = 2'd1;
  localparam logic [1:0] MUL_XX = 2'd2;

  typedef struct packed {
    logic       load;
    logic       restart;
    logic       p1_en;
    logic [1:0] mul_sel;
    logic       fwd_upd;
    logic       div_start;
    logic       bwd_upd;
  } het_cmd_t;

  typedef struct packed {
    logic f_go;
    logic f_lim;
    logic b_go;
    logic b_lim;
    logic div_busy;
  } het_stat_t;

  // Exact magnitude of a signed 32-bit value; the most negative value maps to 2^31.
  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? (~v + 32'd1) : v;
    return r;
  endfunction

  // Saturates a 34-bit signed sum to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat34(input logic [SUM_W-1:0] v);
    logic [DATA_W-1:0] r;
    if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1])) begin
      r = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/het_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module het_div #(
  parameter int NUMW = 49
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [NUMW-1:0]              dividend,
  input  logic [het_pkg::DATA_W-1:0]   divisor,
  output logic                         busy,
  output logic [NUMW-1:0]              quotient
);
  import het_pkg::*;

  localparam int CNTW = $clog2(NUMW + 1);

  logic [CNTW-1:0]   cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [NUMW-1:0]   quo;
  logic [DATA_W:0]   rs;
  logic [DATA_W:0]   diff;
  logic              ge;

  // The partial remainder stays below the divisor, so it always fits 32 bits.
  always_comb begin
    rs   = {rem, quo[NUMW-1]};
    ge   = rs >= {1'b0, dvs};
    diff = rs - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNTW'(NUMW - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : rs[DATA_W-1:0];
      quo <= {quo[NUMW-2:0], ge};
      cnt <= cnt + CNTW'(1);
    end
  end

  assign quotient = quo;

endmodule

// ----- hw/rtl/het_dpath.sv -----
// Datapath: point registers, shared multiplier, divider, step counters and color code.
`timescale 1ns / 1ps

module het_dpath #(
  parameter int FRAC_BITS = het_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  het_pkg::het_cmd_t            cmd,
  input  logic [het_pkg::DATA_W-1:0]   start_x,
  input  logic [het_pkg::DATA_W-1:0]   start_y,
  input  logic [het_pkg::DATA_W-1:0]   c_offset,
  input  logic [het_pkg::DATA_W-1:0]   a_gain,
  input  logic [het_pkg::RAD_W-1:0]    escape_radius,
  input  logic [het_pkg::CNT_W-1:0]    max_iterations,
  output het_pkg::het_stat_t           stat,
  output logic [het_pkg::CODE_W-1:0]   color,
  output logic [het_pkg::CNT_W-1:0]    fcnt,
  output logic [het_pkg::CNT_W-1:0]    bcnt
);
  import het_pkg::*;

  localparam int NUMW = DATA_W + 1 + FRAC_BITS;

  logic [DATA_W-1:0]        x;
  logic [DATA_W-1:0]        y;
  logic [DATA_W-1:0]        x0;
  logic [DATA_W-1:0]        y0;
  logic [DATA_W-1:0]        p1;
  logic [3:0]               fmod;
  logic [3:0]               bmod;
  logic                     num_sgn;
  logic                     num_nz;
  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;
  logic signed [63:0]       prod_w;
  logic signed [63:0]       prod;
  logic signed [63:0]       sh;
  logic [DATA_W-1:0]        satprod;
  logic [SUM_W-1:0]         fsum;
  logic [SUM_W-1:0]         num;
  logic [SUM_W-1:0]         num_mag;
  logic [NUMW-1:0]          dividend;
  logic                     div_busy;
  logic [NUMW-1:0]          quo;
  logic [DATA_W-1:0]        qs;
  logic                     q_neg;
  logic [DATA_W-1:0]        mx;
  logic [DATA_W-1:0]        my;
  logic [DATA_W-1:0]        rad;
  logic                     f_lim;
  logic                     b_lim;
  logic [3:0]               fnib;
  logic [3:0]               bnib;

  het_div #(
    .NUMW(NUMW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (mag32(a_gain)),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Operand selection for the single shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      MUL_AX: begin
        op_a = a_gain;
        op_b = x;
      end
      MUL_XX: begin
        op_a = x;
        op_b = x;
      end
      default: begin
        op_a = y;
        op_b = y;
      end
    endcase
    prod_w = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    prod <= prod_w;
  end

  // Arithmetic shift rounds toward minus infinity; then saturate to 32 bits.
  always_comb begin
    sh = prod >>> FRAC_BITS;
    if ((&sh[63:DATA_W-1]) || !(|sh[63:DATA_W-1])) begin
      satprod = sh[DATA_W-1:0];
    end else if (sh[63]) begin
      satprod = Q_MIN;
    end else begin
      satprod = Q_MAX;
    end
  end

  always_comb begin
    fsum = {{2{p1[DATA_W-1]}}, p1} + {{2{c_offset[DATA_W-1]}}, c_offset}
         - {{2{satprod[DATA_W-1]}}, satprod};
    num  = {{2{satprod[DATA_W-1]}}, satprod} + {{2{c_offset[DATA_W-1]}}, c_offset}
         - {{2{y[DATA_W-1]}}, y};
    num_mag  = num[SUM_W-1] ? (~num + SUM_W'(1)) : num;
    dividend = {num_mag[DATA_W:0], {FRAC_BITS{1'b0}}};
  end

  // Signed quotient from the unsigned divider result, with saturation.
  always_comb begin
    q_neg = num_sgn ^ a_gain[DATA_W-1];
    if (a_gain == '0) begin
      if (num_sgn) begin
        qs = Q_MIN;
      end else if (num_nz) begin
        qs = Q_MAX;
      end else begin
        qs = '0;
      end
    end else if (!q_neg) begin
      qs = (quo > {{(NUMW-DATA_W){1'b0}}, Q_MAX}) ? Q_MAX : quo[DATA_W-1:0];
    end else begin
      qs = (quo > {{(NUMW-DATA_W){1'b0}}, Q_MIN}) ? Q_MIN
         : (~quo[DATA_W-1:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0   <= start_x;
      y0   <= start_y;
      x    <= start_x;
      y    <= start_y;
      fcnt <= '0;
      bcnt <= '0;
      fmod <= '0;
      bmod <= '0;
    end else if (cmd.restart) begin
      x <= x0;
      y <= y0;
    end else if (cmd.fwd_upd) begin
      x    <= y;
      y    <= sat34(fsum);
      fcnt <= fcnt + CNT_W'(1);
      fmod <= (fmod == MOD_LAST) ? 4'd0 : fmod + 4'd1;
    end else if (cmd.bwd_upd) begin
      x    <= qs;
      y    <= x;
      bcnt <= bcnt + CNT_W'(1);
      bmod <= (bmod == MOD_LAST) ? 4'd0 : bmod + 4'd1;
    end
    if (cmd.p1_en) begin
      p1 <= satprod;
    end
    if (cmd.div_start) begin
      num_sgn <= num[SUM_W-1];
      num_nz  <= num != '0;
    end
  end

  always_comb begin
    mx    = mag32(x);
    my    = mag32(y);
    rad   = {1'b0, escape_radius};
    f_lim = fcnt >= max_iterations;
    b_lim = bcnt >= max_iterations;
    stat.f_go     = (mx > my) || (my < rad);
    stat.f_lim    = f_lim;
    stat.b_go     = (mx < my) || (mx < rad);
    stat.b_lim    = b_lim;
    stat.div_busy = div_busy;
    fnib  = f_lim ? 4'd0 : fmod + 4'd1;
    bnib  = b_lim ? 4'd0 : bmod + 4'd1;
    color = (f_lim && b_lim) ? CODE_BOUNDED : {1'b0, fnib, bnib};
  end

endmodule

// ----- hw/rtl/het_ctrl.sv -----
// Controller state machine that sequences the forward and inverse iterations.
`timescale 1ns / 1ps

module het_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_free,
  input  het_pkg::het_stat_t stat,
  output het_pkg::het_cmd_t  cmd,
  output logic               in_stall,
  output logic               res_load
);
  import het_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FCHK = 4'd1;
  localparam logic [3:0] S_FM1  = 4'd2;
  localparam logic [3:0] S_FM2  = 4'd3;
  localparam logic [3:0] S_FUPD = 4'd4;
  localparam logic [3:0] S_BCHK = 4'd5;
  localparam logic [3:0] S_BM1  = 4'd6;
  localparam logic [3:0] S_BNUM = 4'd7;
  localparam logic [3:0] S_BDIV = 4'd8;
  localparam logic [3:0] S_BUPD = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!stat.f_lim && stat.f_go) begin
          state_next = S_FM1;
        end else begin
          // The inverse run starts again from the original point.
          cmd.restart = 1'b1;
          state_next  = S_BCHK;
        end
      end
      S_FM1: begin
        cmd.mul_sel = MUL_YY;
        state_next  = S_FM2;
      end
      S_FM2: begin
        cmd.mul_sel = MUL_AX;
        cmd.p1_en   = 1'b1;
        state_next  = S_FUPD;
      end
      S_FUPD: begin
        cmd.fwd_upd = 1'b1;
        state_next  = S_FCHK;
      end
      S_BCHK: begin
        if (!stat.b_lim && stat.b_go) begin
          state_next = S_BM1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BM1: begin
        cmd.mul_sel = MUL_XX;
        state_next  = S_BNUM;
      end
      S_BNUM: begin
        cmd.div_start = 1'b1;
        state_next    = S_BDIV;
      end
      S_BDIV: begin
        if (!stat.div_busy) begin
          state_next = S_BUPD;
        end
      end
      S_BUPD: begin
        cmd.bwd_upd = 1'b1;
        state_next  = S_BCHK;
      end
      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = state != S_IDLE;

endmodule

// ----- hw/rtl/henon_escape_time.sv -----
// Each forward step passes the controller states FCHK, FM1, FM2 and FUPD on the shared
// multiplier; each inverse step passes BCHK, BM1, BNUM, BDIV and BUPD, and waits in BDIV
// while the bit-serial divider runs.
// Throughput: one point at a time; a new request is taken while the last result waits.
// Reset (rst, synchronous) empties the output register, returns the controller to idle
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`include "henon_escape_time_macros.svh"

module henon_escape_time #(
  parameter int FRAC_BITS = het_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [het_pkg::DATA_W-1:0]      start_x,
  input  logic [het_pkg::DATA_W-1:0]      start_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [het_pkg::CODE_W-1:0]      color_code,
  output logic [het_pkg::CNT_W-1:0]       forward_count,
  output logic [het_pkg::CNT_W-1:0]       backward_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [het_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [het_pkg::DATA_W-1:0]      cfg_data
);
  import het_pkg::*;

  logic [DATA_W-1:0] c_offset;
  logic [DATA_W-1:0] a_gain;
  logic [RAD_W-1:0]  escape_radius;
  logic [CNT_W-1:0]  max_iterations;
  het_cmd_t          cmd;
  het_stat_t         stat;
  logic              res_load;
  logic              out_free;
  logic [CODE_W-1:0] color;
  logic [CNT_W-1:0]  fcnt;
  logic [CNT_W-1:0]  bcnt;
  logic              counts_ok;
  logic              both_at_limit;
  logic              code_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_offset       <= C_OFFSET_RST;
      a_gain         <= A_GAIN_RST;
      escape_radius  <= ESCAPE_RADIUS_RST;
      max_iterations <= MAX_ITER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_C_OFFSET:      c_offset       <= cfg_data;
        REG_A_GAIN:        a_gain         <= cfg_data;
        REG_ESCAPE_RADIUS: escape_radius  <= cfg_data[RAD_W-1:0];
        REG_MAX_ITER:      max_iterations <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  het_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall),
    .res_load (res_load)
  );

  het_dpath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .start_x        (start_x),
    .start_y        (start_y),
    .c_offset       (c_offset),
    .a_gain         (a_gain),
    .escape_radius  (escape_radius),
    .max_iterations (max_iterations),
    .stat           (stat),
    .color          (color),
    .fcnt           (fcnt),
    .bcnt           (bcnt)
  );

  // The output register is free when empty or when its result leaves this cycle.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      color_code     <= color;
      forward_count  <= fcnt;
      backward_count <= bcnt;
    end
  end

  assign counts_ok     = (forward_count <= max_iterations) && (backward_count <= max_iterations);
  assign both_at_limit = (forward_count == max_iterations) && (backward_count == max_iterations);
  assign code_ok       = (color_code == CODE_BOUNDED) == both_at_limit;

  `HET_CHK_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall, "request not taken up")
  `HET_CHK_SAME(a_counts_in_limit, out_valid, counts_ok, "step count beyond limit")
  `HET_CHK_SAME(a_bounded_code, out_valid, code_ok, "color code disagrees with counts")

endmodule
